/* rtl/core/bspline_span_and_basis_eval_core_assert.svh */
// Assertion macros for the B-spline span and basis core.
// Used by the checker module; no other dependencies.
`ifndef BSPLINE_SPAN_AND_BASIS_EVAL_CORE_ASSERT_SVH
`define BSPLINE_SPAN_AND_BASIS_EVAL_CORE_ASSERT_SVH
// assert that a implies b on the next edge
`define BSB_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
// assert that a implies b on the same edge
`define BSB_ASSERT_SAME(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`endif

/* rtl/core/bsb_pkg.sv */
// Package for the B-spline span and basis core: field widths, fixed sizes and codes.
// No dependencies.
package bsb_pkg;
  localparam int FRAC_BITS = 24;
  localparam int MAX_KNOTS = 64;
  localparam int IDX_W = 6;
  localparam int VAL_W = FRAC_BITS + 1;
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;
  localparam logic [IDX_W-1:0] CFG_DEGREE  = 6'd0;
  localparam logic [IDX_W-1:0] CFG_LAST_CP = 6'd1;
  typedef struct packed {
    logic start;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
  } div_req_t;
endpackage

/* rtl/core/bsb_muldiv.sv */
// Serial unit for floor(a*b/c), one bit of b per cycle.
// Depends on bsb_pkg.
module bsb_muldiv
  import bsb_pkg::*;
#(
  parameter int W = 26
) (
  input  logic         clk,
  input  logic         rst,
  input  div_req_t     req,
  output logic         done,
  output logic [W+15:0] q
);
  localparam int BB = W + 16;
  localparam int CW = $clog2(BB + 1);
  logic [W:0] a;
  logic [W:0] c;
  logic [BB-1:0] b;
  logic [W+2:0] rem;
  logic [CW-1:0] cnt;
  logic busy;
  logic [W+2:0] r1;
  logic [W+2:0] r2;
  logic [1:0] qb;
  always_comb begin
    r1 = {rem[W+1:0], 1'b0} + (b[BB-1] ? {2'b0, a} : '0);
    qb = 2'd0;
    r2 = r1;
    if (r2 >= {2'b0, c}) begin
      r2 = r2 - {2'b0, c};
      qb = 2'd1;
    end
    if (r2 >= {2'b0, c}) begin
      r2 = r2 - {2'b0, c};
      qb = 2'd2;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        a <= req.a[W:0];
        b <= req.b[BB-1:0];
        c <= req.c[W:0];
        rem <= '0;
        q <= '0;
        cnt <= CW'(BB);
      end else if (busy) begin
        rem <= r2;
        q <= (q << 1) + {{(BB-2){1'b0}}, qb};
        b <= b << 1;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* rtl/core/bspline_span_and_basis_eval_core.sv */
// Top level of the B-spline span and basis core.
// Depends on bsb_pkg and bsb_muldiv.
//
// A knot write is taken while the core is idle and never stalls. An
// evaluation holds stall high from acceptance until its last word enters
// the output register. It reads the knot memory at most one word a cycle:
// two end checks, a binary search of about log2(n-d+1) probes, each through
// the search, wait and compare states, a seed step, and for each degree
// step the left read, right read and wait states. Each of the d(d+1)/2
// recurrence terms takes a setup state and two serial divisions through
// one shared divider; a term with a zero denominator skips both divisions.
// Results then leave one per accepted word.
module bspline_span_and_basis_eval_core
  import bsb_pkg::*;
#(
  parameter int MAX_DEGREE = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             valid,
  output logic             stall,
  input  logic             func,
  input  logic [IDX_W-1:0] knot_index,
  input  logic [VAL_W-1:0] knot_value,
  input  logic [VAL_W-1:0] param_t,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [IDX_W-1:0] span,
  output logic [IDX_W-1:0] basis_index,
  output logic [VAL_W-1:0] basis_value,
  output logic             last,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0] cfg_data
);
  localparam int AW = $clog2(MAX_KNOTS);
  localparam int FW = FRAC_BITS + 1;
  localparam int SW = AW + 2;
  localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;
  localparam int DMAX0 = (MAX_DEGREE < (MAX_KNOTS - 2) / 2) ? MAX_DEGREE
                         : (MAX_KNOTS - 2) / 2;
  localparam int DW = $clog2(MAX_DEGREE + 2);
  localparam int JW = $clog2(MAX_DEGREE + 1);
  localparam int QW = FW + 17;
  localparam logic [3:0] S_IDLE = 4'd0, S_CHK1 = 4'd1, S_CHK2 = 4'd2,
    S_CHK3 = 4'd3, S_SRCH = 4'd4, S_SWAIT = 4'd5, S_SCMP = 4'd6,
    S_LRD = 4'd7, S_RRD = 4'd8, S_RWAIT = 4'd9, S_DIV1 = 4'd10,
    S_DIV1W = 4'd11, S_DIV2W = 4'd12, S_OUT = 4'd13;

  logic [FW-1:0] kmem [MAX_KNOTS];
  logic [FW-1:0] rdata;
  logic [AW-1:0] raddr;
  logic ren;

  logic [3:0] state;
  logic [1:0] deg_r;
  logic [IDX_W-1:0] ncp_r;
  logic [DW-1:0] d;
  logic [SW-1:0] n;
  logic [FW-1:0] t;
  logic [SW-1:0] lo, hi, mid, sp;
  logic [DW-1:0] j, r, oj;
  logic [DW-1:0] r1;
  logic [JW-1:0] ri, r1i, ji, jri, oji;
  logic [FW-1:0] nb [MAX_DEGREE+1];
  logic [FW:0] lf [MAX_DEGREE+1];
  logic [FW:0] rt [MAX_DEGREE+1];
  logic [FW-1:0] saved, term;
  div_req_t dreq;
  logic ddone;
  logic [QW-1:0] dq;

  logic [SW-1:0] dc_i, nc_i, nmax;
  logic [FW-1:0] kv_sat, t_sat, qsat;
  logic [FW+1:0] denom;
  logic [FW:0] ssum;

  assign kv_sat = ({1'b0, knot_value} > {1'b0, ONE}) ? ONE
                  : knot_value[FW-1:0];
  assign t_sat = (param_t > ONE) ? ONE : param_t[FW-1:0];
  always_comb begin
    dc_i = SW'(deg_r);
    if (dc_i < SW'(1)) dc_i = SW'(1);
    if (dc_i > SW'(DMAX0)) dc_i = SW'(DMAX0);
    nmax = SW'(MAX_KNOTS - 2) - dc_i;
    nc_i = SW'(ncp_r);
    if (nc_i < dc_i) nc_i = dc_i;
    if (nc_i > nmax) nc_i = nmax;
  end
  assign r1 = r + 1'b1;
  assign ri = r[JW-1:0];
  assign r1i = r1[JW-1:0];
  assign ji = j[JW-1:0];
  assign jri = JW'(j - r);
  assign oji = oj[JW-1:0];
  assign denom = {1'b0, rt[r1i]} + {1'b0, lf[jri]};
  assign qsat = (dq > QW'(ONE)) ? ONE : dq[FW-1:0];
  assign ssum = {1'b0, saved} + {1'b0, term};

  assign stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign mid = SW'(({1'b0, lo} + {1'b0, hi}) >> 1);

  always_ff @(posedge clk) begin
    if (valid && !stall && func == FUNC_WRITE && 32'(knot_index) < MAX_KNOTS)
      kmem[knot_index[AW-1:0]] <= kv_sat;
    if (ren) rdata <= kmem[raddr];
  end

  always_comb begin
    ren = 1'b1;
    raddr = '0;
    case (state)
      S_CHK1: raddr = AW'(n + 1'b1);
      S_CHK2: raddr = AW'(d);
      S_SRCH: raddr = AW'(mid);
      S_LRD:  raddr = AW'(sp + 1'b1 - SW'(j));
      S_RRD:  raddr = AW'(sp + SW'(j));
      default: ren = 1'b0;
    endcase
  end

  always_comb begin
    dreq.start = 1'b0;
    dreq.a = 64'(rt[r1i]);
    dreq.b = 64'(nb[ri]);
    dreq.c = 64'(denom);
    if (state == S_DIV1 && denom != '0) dreq.start = 1'b1;
    if (state == S_DIV1W && ddone) begin
      dreq.start = 1'b1;
      dreq.a = 64'(lf[jri]);
    end
  end

  bsb_muldiv #(.W(FW + 1)) u_div (
    .clk(clk), .rst(rst), .req(dreq), .done(ddone), .q(dq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      deg_r <= 2'd3;
      ncp_r <= 6'd3;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DEGREE) deg_r <= cfg_data[1:0];
        else if (cfg_index == CFG_LAST_CP) ncp_r <= cfg_data[IDX_W-1:0];
      end
      case (state)
        S_IDLE: begin
          if (valid && func == FUNC_EVAL) begin
            d <= DW'(dc_i);
            n <= nc_i;
            t <= t_sat;
            state <= S_CHK1;
          end
        end
        S_CHK1: state <= S_CHK2;
        S_CHK2: begin
          if (t >= rdata) begin
            sp <= n;
            state <= S_LRD;
          end else state <= S_CHK3;
        end
        S_CHK3: begin
          if (t <= rdata) begin
            sp <= SW'(d);
            state <= S_LRD;
          end else begin
            lo <= SW'(d);
            hi <= n + 1'b1;
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (hi - lo > SW'(1)) state <= S_SWAIT;
          else begin
            sp <= lo;
            state <= S_LRD;
          end
        end
        S_SWAIT: state <= S_SCMP;
        S_SCMP: begin
          if (t < rdata) hi <= mid;
          else lo <= mid;
          state <= S_SRCH;
        end
        S_LRD: begin
          if (j == DW'(0)) begin
            nb[0] <= ONE;
            j <= DW'(1);
          end else state <= S_RRD;
        end
        S_RRD: begin
          lf[ji] <= (t >= rdata) ? {1'b0, t - rdata} : '0;
          state <= S_RWAIT;
        end
        S_RWAIT: begin
          rt[ji] <= (rdata >= t) ? {1'b0, rdata - t} : '0;
          r <= '0;
          saved <= '0;
          state <= S_DIV1;
        end
        S_DIV1: begin
          if (denom == '0) begin
            nb[ri] <= saved;
            saved <= '0;
            if (r1 == j) begin
              nb[ji] <= '0;
              state <= (j == d) ? S_OUT : S_LRD;
              j <= j + 1'b1;
              oj <= '0;
            end else r <= r1;
          end else state <= S_DIV1W;
        end
        S_DIV1W: if (ddone) begin
          term <= qsat;
          state <= S_DIV2W;
        end
        S_DIV2W: if (ddone) begin
          nb[ri] <= (ssum > {1'b0, ONE}) ? ONE : ssum[FW-1:0];
          saved <= qsat;
          if (r1 == j) begin
            nb[ji] <= qsat;
            state <= (j == d) ? S_OUT : S_LRD;
            j <= j + 1'b1;
            oj <= '0;
          end else begin
            r <= r1;
            state <= S_DIV1;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            span <= IDX_W'(sp);
            basis_index <= IDX_W'(sp - SW'(d) + SW'(oj));
            basis_value <= VAL_W'(nb[oji]);
            last <= (oj == d);
            oj <= oj + 1'b1;
            if (oj == d) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_IDLE && valid) j <= '0;
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
    end
  end
endmodule

/* rtl/core/bsb_checker.sv */
// Port-level checker for the B-spline span and basis core.
// Depends on the assertion macro header; bound to the top level.
`include "bspline_span_and_basis_eval_core_assert.svh"
module bsb_checker (
  input logic clk,
  input logic rst,
  input logic stall,
  input logic out_valid,
  input logic out_stall,
  input logic last,
  input logic [5:0] span,
  input logic [5:0] basis_index
);
  `BSB_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(span))
  `BSB_ASSERT_SAME(a_busy_out, clk, rst, out_valid && !last, stall)
  `BSB_ASSERT_NEXT(a_last_idle, clk, rst, out_valid && !out_stall && last, !out_valid)
  `BSB_ASSERT_SAME(a_idx, clk, rst, out_valid && last, basis_index == span)
endmodule

bind bspline_span_and_basis_eval_core bsb_checker u_chk (
  .clk(clk), .rst(rst), .stall(stall), .out_valid(out_valid),
  .out_stall(out_stall), .last(last), .span(span), .basis_index(basis_index)
);
